[sv/vtts_pkg.sv]
package vtts_pkg;

  typedef enum logic [1:0] {
    CMD_SPAWN    = 2'd0,
    CMD_DISPATCH = 2'd1,
    CMD_REPORT   = 2'd2,
    CMD_NOP      = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    OUT_RUN   = 2'd0,
    OUT_SLEEP = 2'd1,
    OUT_KILL  = 2'd2,
    OUT_RSVD  = 2'd3
  } outcome_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] time_us;
    logic [7:0]  weight;
    logic [1:0]  outcome;
    logic [31:0] elapsed_us;
    logic [31:0] sleep_ms;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        head_valid;
    logic [3:0]  head_task;
    logic [3:0]  new_task;
    logic [63:0] now_wide;
  } out_word_t;

  localparam logic [9:0] MS_TO_US = 10'd1000;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_HEADRD,   // read head slot's time
    S_HEADWT,
    S_WKRD,     // read sleep head's wake time
    S_WKWT,
    S_MUL,
    S_RPT,
    S_BRD,      // bubble: read key of the entry after the moved one
    S_BWT,
    S_DONE
  } state_t;

endpackage

[sv/vtts_ram.sv]
module vtts_ram #(
  parameter int Depth = 16,
  parameter int Width = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/virtual_time_task_scheduler.sv]
// Channel | Ports                        | Word
// in      | in_valid in_ready in_word    | one command word
// out     | out_valid out_ready out_word | one result word per command
// A spawn, no-op or empty report goes from the head read to the result; a kill
// updates and drops its slot; a dispatch wakes each due sleeper in turn; other
// reports update the entry and then bubble it, swapping while it is out of order.
// The block returns to idle as the result is raised, so the next command can
// be taken at the following edge; each slot memory has one read port.
// Reset (rst_n, synchronous) empties both lists and frees every slot.
// A result waits in the output register; the final state stalls only while
// that register still holds an untaken word.
module virtual_time_task_scheduler
  import vtts_pkg::*;
#(
  parameter int MAX_TASKS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  localparam int SW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam logic [CW-1:0] FULL = CW'(MAX_TASKS);

  state_t state_r, state_nxt;

  in_word_t        cmd_r;
  logic [31:0]     last_raw_r, wrap_r;
  logic [63:0]     now_r;
  logic [CW-1:0]   run_cnt_r, sleep_cnt_r;
  logic [MAX_TASKS-1:0] used_r;
  logic [SW-1:0]   run_list_r [MAX_TASKS];
  logic [SW-1:0]   sleep_list_r [MAX_TASKS];
  logic [7:0]      weight_r [MAX_TASKS];
  logic [1:0]      status_r;
  logic [3:0]      new_task_r;
  logic            out_valid_r;
  out_word_t       out_word_r;
  logic [63:0]     hv_r;        // head virtual time at the start of a report
  logic [63:0]     key0_r;      // key of the entry being bubbled
  logic [SW-1:0]   idx_r;       // position of the bubbled entry
  logic            bsel_r;      // bubble on sleep list
  logic [SW-1:0]   slot_r;
  logic [39:0]     prod_r;
  logic [41:0]     slp_r;

  // Memories: virtual time and wake time, one write and one read port each.
  logic          vt_we, wt_we;
  logic [SW-1:0] vt_wa, wt_wa, vt_ra, wt_ra;
  logic [63:0]   vt_wd, wt_wd, vt_rd, wt_rd;

  vtts_ram #(.Depth(MAX_TASKS), .Width(64)) u_vt (
    .clk(clk), .we(vt_we), .waddr(vt_wa), .wdata(vt_wd), .raddr(vt_ra), .rdata(vt_rd));
  vtts_ram #(.Depth(MAX_TASKS), .Width(64)) u_wt (
    .clk(clk), .we(wt_we), .waddr(wt_wa), .wdata(wt_wd), .raddr(wt_ra), .rdata(wt_rd));

  // Lowest free slot.
  logic [SW-1:0] free_slot;
  logic          free_ok;
  always_comb begin
    free_slot = '0;
    free_ok   = 1'b0;
    for (int k = MAX_TASKS - 1; k >= 0; k--) begin
      if (!used_r[k]) begin
        free_slot = SW'(k);
        free_ok   = 1'b1;
      end
    end
  end

  // Time extension.
  logic [31:0] wrap_nxt;
  assign wrap_nxt = (in_word.time_us < last_raw_r) ? wrap_r + 32'd1 : wrap_r;

  // Values derived from the memory read data and the report registers.
  logic [63:0] head_vt, new_vt, wake_at;
  assign head_vt = (run_cnt_r != '0) ? vt_rd : '0;
  assign new_vt  = hv_r + {24'd0, prod_r};
  assign wake_at = now_r + {22'd0, slp_r};

  logic can_spawn, wake_due;
  assign can_spawn = free_ok && (run_cnt_r < FULL);
  assign wake_due  = (sleep_cnt_r != '0) && (wt_rd < now_r);

  // Bubble pass operands.
  logic [SW-1:0] idx1_s, bslot0, bslot1;
  assign idx1_s = idx_r + SW'(1);
  assign bslot0 = bsel_r ? sleep_list_r[idx_r] : run_list_r[idx_r];
  assign bslot1 = bsel_r ? sleep_list_r[idx1_s] : run_list_r[idx1_s];
  logic [CW-1:0] bcnt;
  assign bcnt = bsel_r ? sleep_cnt_r : run_cnt_r;
  logic bmore, bswap;
  assign bmore = (CW'(idx_r) + CW'(1)) < bcnt;
  logic [63:0] bkey1;
  assign bkey1 = bsel_r ? wt_rd : vt_rd;
  assign bswap = bkey1 < key0_r;

  // Next state and memory access control.
  always_comb begin
    state_nxt = state_r;
    vt_we = 1'b0; vt_wa = slot_r; vt_wd = new_vt;
    wt_we = 1'b0; wt_wa = slot_r; wt_wd = wake_at;
    vt_ra = run_list_r[0];
    wt_ra = sleep_list_r[0];
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_HEADRD;
      S_HEADRD: state_nxt = S_HEADWT;
      S_HEADWT: begin
        unique case (cmd_t'(cmd_r.command))
          CMD_SPAWN: begin
            state_nxt = S_DONE;
            if (can_spawn) begin
              vt_we = 1'b1; vt_wa = free_slot; vt_wd = head_vt;
            end
          end
          CMD_DISPATCH: state_nxt = S_WKRD;
          CMD_REPORT:   state_nxt = (run_cnt_r == '0) ? S_DONE : S_MUL;
          CMD_NOP:      state_nxt = S_DONE;
        endcase
      end
      S_WKRD:   state_nxt = S_WKWT;
      S_WKWT: begin
        // A woken slot takes the head's time and goes on the front of the run list without a bubble pass.
        if (wake_due) begin
          vt_we = 1'b1; vt_wa = sleep_list_r[0]; vt_wd = head_vt;
          state_nxt = S_WKRD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_MUL:    state_nxt = S_RPT;
      S_RPT: begin
        vt_we = 1'b1;
        wt_we = (outcome_t'(cmd_r.outcome) == OUT_SLEEP);
        state_nxt = (outcome_t'(cmd_r.outcome) == OUT_KILL) ? S_DONE : S_BRD;
      end
      S_BRD: begin
        vt_ra = bslot1;
        wt_ra = bslot1;
        state_nxt = bmore ? S_BWT : S_DONE;
      end
      S_BWT:    state_nxt = bswap ? S_BRD : S_DONE;
      S_DONE:   if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequencer datapath.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_raw_r  <= '0;
      wrap_r      <= '0;
      run_cnt_r   <= '0;
      sleep_cnt_r <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Result register.
      if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
        out_valid_r          <= 1'b1;
        out_word_r.status    <= status_r;
        out_word_r.head_valid <= (run_cnt_r != '0);
        out_word_r.head_task <= (run_cnt_r != '0) ? 4'(run_list_r[0]) : 4'd0;
        out_word_r.new_task  <= new_task_r;
        out_word_r.now_wide  <= now_r;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: if (in_valid) begin
          cmd_r      <= in_word;
          wrap_r     <= wrap_nxt;
          last_raw_r <= in_word.time_us;
          now_r      <= {wrap_nxt, in_word.time_us};
          status_r   <= ST_OK;
          new_task_r <= '0;
        end
        S_HEADWT: begin
          hv_r   <= head_vt;
          slot_r <= run_list_r[0];
          unique case (cmd_t'(cmd_r.command))
            CMD_SPAWN: begin
              if (can_spawn) begin
                used_r[free_slot]   <= 1'b1;
                weight_r[free_slot] <= cmd_r.weight;
                new_task_r          <= 4'(free_slot);
                for (int k = MAX_TASKS - 1; k > 0; k--)
                  run_list_r[SW'(k)] <= run_list_r[SW'(k - 1)];
                run_list_r[0] <= free_slot;
                run_cnt_r     <= run_cnt_r + CW'(1);
              end else begin
                status_r <= ST_FULL;
              end
            end
            CMD_REPORT: if (run_cnt_r == '0) status_r <= ST_EMPTY;
            default: ;
          endcase
        end
        S_WKWT: if (wake_due) begin
          // Pop the sleep head and push it on the run list.
          for (int k = 0; k < MAX_TASKS - 1; k++)
            sleep_list_r[SW'(k)] <= sleep_list_r[SW'(k + 1)];
          sleep_cnt_r <= sleep_cnt_r - CW'(1);
          for (int k = MAX_TASKS - 1; k > 0; k--)
            run_list_r[SW'(k)] <= run_list_r[SW'(k - 1)];
          run_list_r[0] <= sleep_list_r[0];
          run_cnt_r     <= run_cnt_r + CW'(1);
        end
        S_MUL: begin
          prod_r <= 40'(cmd_r.elapsed_us) * 40'(weight_r[slot_r]);
          slp_r  <= 42'(cmd_r.sleep_ms) * 42'(MS_TO_US);
        end
        S_RPT: begin
          idx_r <= '0;
          unique case (outcome_t'(cmd_r.outcome))
            OUT_SLEEP: begin
              key0_r <= wake_at;
              bsel_r <= 1'b1;
              for (int k = 0; k < MAX_TASKS - 1; k++)
                run_list_r[SW'(k)] <= run_list_r[SW'(k + 1)];
              run_cnt_r <= run_cnt_r - CW'(1);
              for (int k = MAX_TASKS - 1; k > 0; k--)
                sleep_list_r[SW'(k)] <= sleep_list_r[SW'(k - 1)];
              sleep_list_r[0] <= slot_r;
              sleep_cnt_r     <= sleep_cnt_r + CW'(1);
            end
            OUT_KILL: begin
              for (int k = 0; k < MAX_TASKS - 1; k++)
                run_list_r[SW'(k)] <= run_list_r[SW'(k + 1)];
              run_cnt_r      <= run_cnt_r - CW'(1);
              used_r[slot_r] <= 1'b0;
            end
            OUT_RUN, OUT_RSVD: begin
              // Still running: bubble from the head.
              key0_r <= new_vt;
              bsel_r <= 1'b0;
            end
          endcase
        end
        S_BWT: if (bswap) begin
          if (bsel_r) begin
            sleep_list_r[idx_r]  <= bslot1;
            sleep_list_r[idx1_s] <= bslot0;
          end else begin
            run_list_r[idx_r]  <= bslot1;
            run_list_r[idx1_s] <= bslot0;
          end
          idx_r <= idx1_s;
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  // The run and sleep lists together never hold more than the slot count.
  a_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(run_cnt_r) + 32'(sleep_cnt_r)) <= MAX_TASKS)
    else $error("list counts exceed slot count");
  // A waiting result word stays put until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_word_r))
    else $error("result word changed while waiting");
  // A result word is raised only from the final state.
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result raised outside final state");
  // Between commands the count of used slots equals the two list counts together.
  a_slots: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> $countones(used_r) == 32'(run_cnt_r) + 32'(sleep_cnt_r))
    else $error("used slots and list counts disagree");
`endif

endmodule
